// ----- rtl/core/rnct_pkg.sv -----
// shared types, constants and helpers for the residual norm convergence test
// depends on nothing; used by every module in rtl/core
package rnct_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int ACC_W = 64;
	localparam int IDX_W = 16;
	localparam int ADDR_W = 5;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// test modes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_L2 = 2'd1;
	localparam logic [1:0] MODE_MAX = 2'd2;

	// register indexes
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_SCALE_EN = 3'd1;
	localparam logic [2:0] REG_ALG_COEF = 3'd2;
	localparam logic [2:0] REG_RES_SCALE = 3'd3;
	localparam logic [2:0] REG_TOL = 3'd4;
	localparam logic [2:0] REG_FIRST = 3'd5;
	localparam logic [2:0] REG_LAST = 3'd6;

	typedef struct packed {
		logic [1:0] test_mode;
		logic scale_enable;
		logic [DATA_W-1:0] algebraic_coef;
		logic [DATA_W-1:0] result_scale;
		logic [DATA_W-1:0] tolerance;
		logic [IDX_W-1:0] range_first;
		logic [IDX_W-1:0] range_last;
	} cfg_t;

	// one classified element between front and back
	typedef struct packed {
		logic [DATA_W-1:0] mag;
		logic [ACC_W-1:0] sq;
		logic use_elem;
		logic diff;
		logic sat;
		logic last;
		logic others;
	} elem_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_SCALE,
		F_COEF,
		F_SQ,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_RUN,
		B_SQRT_INIT,
		B_SQRT,
		B_SCALE,
		B_OUT
	} back_state_t;

	// q-format product truncated and saturated to 32 bits
	function automatic logic [DATA_W-1:0] qsat(input logic [ACC_W-1:0] p);
		logic [ACC_W-1:0] s;
		s = p >> FRAC_BITS;
		qsat = (|s[ACC_W-1:DATA_W]) ? {DATA_W{1'b1}} : s[DATA_W-1:0];
	endfunction

	function automatic logic qovf(input logic [ACC_W-1:0] p);
		logic [ACC_W-1:0] s;
		s = p >> FRAC_BITS;
		qovf = |s[ACC_W-1:DATA_W];
	endfunction

endpackage

// ----- rtl/core/rnct_front.sv -----
// front part: accepts elements, classifies them and forms magnitude and square
// depends on rnct_pkg; one shared 32x32 multiplier, used three times
module rnct_front (
	input  logic clk,
	input  logic arst_n,
	input  rnct_pkg::cfg_t cfg,
	input  logic push,
	output logic full,
	input  logic [31:0] residual_value,
	input  logic [31:0] element_scale,
	input  logic is_differential,
	input  logic [15:0] element_index,
	input  logic others_converged,
	input  logic last_element,
	output logic q_push,
	output rnct_pkg::elem_t q_data,
	input  logic q_full
);

	rnct_pkg::front_state_t state_q, state_d;
	logic [31:0] mag_q;
	logic [31:0] escale_q;
	logic [63:0] sq_q;
	logic diff_q, use_q, sat_q, last_q, others_q;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic accept, in_range, active;

	assign accept = push && !full;
	assign full = (state_q != rnct_pkg::F_IDLE);
	// index above the maximum element count cannot occur at 16 bits
	assign in_range = (element_index >= cfg.range_first) && (element_index <= cfg.range_last);
	assign active = (cfg.test_mode == rnct_pkg::MODE_L2) || (cfg.test_mode == rnct_pkg::MODE_MAX);

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			rnct_pkg::F_SCALE: mul_b = escale_q;
			rnct_pkg::F_COEF:  mul_b = cfg.algebraic_coef;
			default:           mul_b = mag_q;
		endcase
	end
	assign prod = {32'd0, mag_q} * {32'd0, mul_b};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rnct_pkg::F_IDLE:  if (accept) state_d = rnct_pkg::F_SCALE;
			rnct_pkg::F_SCALE: state_d = rnct_pkg::F_COEF;
			rnct_pkg::F_COEF:  state_d = rnct_pkg::F_SQ;
			rnct_pkg::F_SQ:    state_d = rnct_pkg::F_PUSH;
			rnct_pkg::F_PUSH:  if (!q_full) state_d = rnct_pkg::F_IDLE;
			default:           state_d = rnct_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rnct_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// element datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rnct_pkg::F_IDLE: begin
				if (accept) begin
					mag_q <= residual_value[31] ? (~residual_value + 32'd1) : residual_value;
					escale_q <= element_scale;
					diff_q <= is_differential;
					use_q <= active && in_range;
					last_q <= last_element;
					others_q <= others_converged;
					sat_q <= 1'b0;
				end
			end
			rnct_pkg::F_SCALE: begin
				if (cfg.scale_enable) begin
					mag_q <= rnct_pkg::qsat(prod);
					sat_q <= sat_q | rnct_pkg::qovf(prod);
				end
			end
			rnct_pkg::F_COEF: begin
				if (!diff_q) begin
					mag_q <= rnct_pkg::qsat(prod);
					sat_q <= sat_q | rnct_pkg::qovf(prod);
				end
			end
			rnct_pkg::F_SQ: begin
				sq_q <= prod;
			end
			default: begin
			end
		endcase
	end

	assign q_push = (state_q == rnct_pkg::F_PUSH) && !q_full;
	assign q_data = '{mag: mag_q, sq: sq_q, use_elem: use_q, diff: diff_q, sat: sat_q,
		last: last_q, others: others_q};

endmodule

// ----- rtl/core/rnct_queue.sv -----
// short queue of classified elements between front and back
// depends on rnct_pkg for the element type and depth
module rnct_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  rnct_pkg::elem_t wdata,
	output logic q_full,
	input  logic rd,
	output rnct_pkg::elem_t rdata,
	output logic q_empty
);

	rnct_pkg::elem_t mem_q [rnct_pkg::QDEPTH];
	logic [rnct_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [rnct_pkg::QPTR_W:0] count_q;

	assign q_full = (count_q == (rnct_pkg::QPTR_W+1)'(rnct_pkg::QDEPTH));
	assign q_empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			if (wr && !rd) count_q <= count_q + 1'b1;
			else if (rd && !wr) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wdata;
	end

endmodule

// ----- rtl/core/rnct_back.sv -----
// back part: accumulates elements, takes L2 square roots and forms the result word
// depends on rnct_pkg; one root bit per cycle, one multiplier for the result scale
module rnct_back (
	input  logic clk,
	input  logic arst_n,
	input  rnct_pkg::cfg_t cfg,
	input  rnct_pkg::elem_t q_data,
	input  logic q_empty,
	output logic q_pop,
	output logic empty,
	input  logic pop,
	output logic [31:0] test_value,
	output logic [31:0] diff_test_value,
	output logic converged,
	output logic diverged
);

	rnct_pkg::back_state_t state_q, state_d;
	logic [63:0] main_acc_q, diff_acc_q;
	logic ovf_q, others_q;
	logic [63:0] xm_q, rm_q, xd_q, rd_q, bit_q;
	logic [63:0] prod_q;
	logic [31:0] tv;
	logic out_valid_q;
	logic [64:0] sum_m, sum_d;
	logic [63:0] tm, td;
	logic l2;

	assign l2 = (cfg.test_mode == rnct_pkg::MODE_L2);
	assign q_pop = (state_q == rnct_pkg::B_RUN) && !q_empty;
	assign sum_m = {1'b0, main_acc_q} + {1'b0, q_data.sq};
	assign sum_d = {1'b0, diff_acc_q} + {1'b0, q_data.sq};
	assign tm = rm_q + bit_q;
	assign td = rd_q + bit_q;
	assign tv = rnct_pkg::qsat(prod_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rnct_pkg::B_RUN:       if (q_pop && q_data.last) state_d = rnct_pkg::B_SQRT_INIT;
			rnct_pkg::B_SQRT_INIT: state_d = l2 ? rnct_pkg::B_SQRT : rnct_pkg::B_SCALE;
			rnct_pkg::B_SQRT:      if (bit_q == 64'd1) state_d = rnct_pkg::B_SCALE;
			rnct_pkg::B_SCALE:     state_d = rnct_pkg::B_OUT;
			rnct_pkg::B_OUT:       if (!out_valid_q) state_d = rnct_pkg::B_RUN;
			default:               state_d = rnct_pkg::B_RUN;
		endcase
	end

	// control state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rnct_pkg::B_RUN;
			main_acc_q <= '0;
			diff_acc_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && q_data.use_elem) begin
				if (q_data.sat) ovf_q <= 1'b1;
				if (l2) begin
					main_acc_q <= sum_m[64] ? '1 : sum_m[63:0];
					if (sum_m[64]) ovf_q <= 1'b1;
					if (q_data.diff) begin
						diff_acc_q <= sum_d[64] ? '1 : sum_d[63:0];
						if (sum_d[64]) ovf_q <= 1'b1;
					end
				end else begin
					if ({32'd0, q_data.mag} > main_acc_q) main_acc_q <= {32'd0, q_data.mag};
					if (q_data.diff && ({32'd0, q_data.mag} > diff_acc_q))
						diff_acc_q <= {32'd0, q_data.mag};
				end
			end
			// result word out, state cleared for the next vector
			if (state_q == rnct_pkg::B_OUT && !out_valid_q) begin
				out_valid_q <= 1'b1;
				main_acc_q <= '0;
				diff_acc_q <= '0;
				ovf_q <= 1'b0;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// square root iterations and result datapath
	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) others_q <= q_data.others;
		case (state_q)
			rnct_pkg::B_SQRT_INIT: begin
				xm_q <= main_acc_q;
				xd_q <= diff_acc_q;
				bit_q <= 64'd1 << 62;
				rm_q <= l2 ? 64'd0 : {32'd0, main_acc_q[31:0]};
				rd_q <= l2 ? 64'd0 : {32'd0, diff_acc_q[31:0]};
			end
			rnct_pkg::B_SQRT: begin
				if (xm_q >= tm) begin
					xm_q <= xm_q - tm;
					rm_q <= (rm_q >> 1) + bit_q;
				end else begin
					rm_q <= rm_q >> 1;
				end
				if (xd_q >= td) begin
					xd_q <= xd_q - td;
					rd_q <= (rd_q >> 1) + bit_q;
				end else begin
					rd_q <= rd_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			rnct_pkg::B_SCALE: begin
				prod_q <= {32'd0, rm_q[31:0]} * {32'd0, cfg.result_scale};
			end
			rnct_pkg::B_OUT: begin
				if (!out_valid_q) begin
					test_value <= tv;
					diff_test_value <= rd_q[31:0];
					diverged <= ovf_q;
					converged <= (tv <= cfg.tolerance) && others_q && !ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign empty = !out_valid_q;

endmodule

// ----- rtl/core/residual_norm_convergence_test.sv -----
// top level of the residual norm convergence test: registers, front, queue, back
// depends on rnct_pkg, rnct_front, rnct_queue and rnct_back
//
// channel   direction  handshake            payload
// elements  in         push / full          residual_value .. last_element
// results   out        empty / pop          test_value .. diverged
// config    in         psel/penable/pready  paddr, pwdata, prdata
//
// each element holds the front from F_SCALE to F_PUSH (one shared multiplier used
// three times); the back accumulates one element a cycle from a non-empty queue in
// B_RUN; a last element adds set-up, 32 one-bit root steps (L2 only), scale, output
// reset clears control state, accumulators and registers to their reset values
// a held result blocks only the back; the queue lets the front go on
module residual_norm_convergence_test (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [31:0] residual_value,
	input  logic [31:0] element_scale,
	input  logic is_differential,
	input  logic [15:0] element_index,
	input  logic others_converged,
	input  logic last_element,
	output logic empty,
	input  logic pop,
	output logic [31:0] test_value,
	output logic [31:0] diff_test_value,
	output logic converged,
	output logic diverged,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rnct_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	rnct_pkg::cfg_t cfg_q;
	rnct_pkg::elem_t q_wdata, q_rdata;
	logic q_push, q_full, q_pop, q_empty, wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.test_mode <= rnct_pkg::MODE_L2;
			cfg_q.scale_enable <= 1'b0;
			cfg_q.algebraic_coef <= 32'd1 << rnct_pkg::FRAC_BITS;
			cfg_q.result_scale <= 32'd1 << rnct_pkg::FRAC_BITS;
			cfg_q.tolerance <= '0;
			cfg_q.range_first <= 16'd1;
			cfg_q.range_last <= 16'hFFFF;
		end else if (wr_en) begin
			case (reg_idx)
				rnct_pkg::REG_MODE:      cfg_q.test_mode <= pwdata[1:0];
				rnct_pkg::REG_SCALE_EN:  cfg_q.scale_enable <= pwdata[0];
				rnct_pkg::REG_ALG_COEF:  cfg_q.algebraic_coef <= pwdata;
				rnct_pkg::REG_RES_SCALE: cfg_q.result_scale <= pwdata;
				rnct_pkg::REG_TOL:       cfg_q.tolerance <= pwdata;
				rnct_pkg::REG_FIRST:     cfg_q.range_first <= pwdata[15:0];
				rnct_pkg::REG_LAST:      cfg_q.range_last <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			rnct_pkg::REG_MODE:      prdata = {30'd0, cfg_q.test_mode};
			rnct_pkg::REG_SCALE_EN:  prdata = {31'd0, cfg_q.scale_enable};
			rnct_pkg::REG_ALG_COEF:  prdata = cfg_q.algebraic_coef;
			rnct_pkg::REG_RES_SCALE: prdata = cfg_q.result_scale;
			rnct_pkg::REG_TOL:       prdata = cfg_q.tolerance;
			rnct_pkg::REG_FIRST:     prdata = {16'd0, cfg_q.range_first};
			rnct_pkg::REG_LAST:      prdata = {16'd0, cfg_q.range_last};
			default:                 prdata = '0;
		endcase
	end

	rnct_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.push(push), .full(full),
		.residual_value(residual_value), .element_scale(element_scale),
		.is_differential(is_differential), .element_index(element_index),
		.others_converged(others_converged), .last_element(last_element),
		.q_push(q_push), .q_data(q_wdata), .q_full(q_full)
	);

	rnct_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(q_push), .wdata(q_wdata), .q_full(q_full),
		.rd(q_pop), .rdata(q_rdata), .q_empty(q_empty)
	);

	rnct_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_data(q_rdata), .q_empty(q_empty), .q_pop(q_pop),
		.empty(empty), .pop(pop),
		.test_value(test_value), .diff_test_value(diff_test_value),
		.converged(converged), .diverged(diverged)
	);

	// queue never written when full nor read when empty
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("element queue overrun");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("element queue underrun");
	// front busy right after taking a word
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n) (push && !full) |=> full)
		else $error("front took no word");
	// a diverged vector is never reported converged
	a_conv_div: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(converged && diverged))
		else $error("converged and diverged together");

endmodule

// ----- test/rnct_checker.sv -----
// checker for the residual norm convergence test: watches element, result and
// register channels, predicts each vector result and compares; needs rnct_pkg
module rnct_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic [31:0] residual_value,
	input  logic [31:0] element_scale,
	input  logic is_differential,
	input  logic [15:0] element_index,
	input  logic others_converged,
	input  logic last_element,
	input  logic empty,
	input  logic pop,
	input  logic [31:0] test_value,
	input  logic [31:0] diff_test_value,
	input  logic converged,
	input  logic diverged,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rnct_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int fail_count,
	output int pending,
	output int vectors_seen
);

	typedef struct packed {
		logic [31:0] tv;
		logic [31:0] dv;
		logic conv;
		logic div;
	} verdict_t;

	verdict_t verdicts_due[$];
	rnct_pkg::cfg_t cfg;
	logic [63:0] main_sum, diff_sum;
	logic ovf;

	// truncated q product, flags saturation
	function automatic logic [31:0] qprod(input logic [31:0] a, input logic [31:0] b,
			inout logic s);
		logic [63:0] p;
		p = ({32'd0, a} * {32'd0, b}) >> rnct_pkg::FRAC_BITS;
		if (p[63:32] != 0) begin
			s = 1'b1;
			return 32'hFFFF_FFFF;
		end
		return p[31:0];
	endfunction

	function automatic logic [31:0] root64(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	function automatic logic [63:0] fold(input logic [63:0] acc, input logic [31:0] m,
			inout logic o);
		logic [63:0] sq;
		sq = {32'd0, m} * {32'd0, m};
		if (cfg.test_mode == rnct_pkg::MODE_L2) begin
			if (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
				o = 1'b1;
				return 64'hFFFF_FFFF_FFFF_FFFF;
			end
			return acc + sq;
		end
		if (cfg.test_mode == rnct_pkg::MODE_MAX && {32'd0, m} > acc) return {32'd0, m};
		return acc;
	endfunction

	function automatic logic [31:0] closing(input logic [63:0] acc);
		if (cfg.test_mode == rnct_pkg::MODE_L2) return root64(acc);
		if (cfg.test_mode == rnct_pkg::MODE_MAX)
			return (acc[63:32] != 0) ? 32'hFFFF_FFFF : acc[31:0];
		return 32'd0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] m;
		logic s, dummy;
		verdict_t v, got;
		if (!arst_n) begin
			cfg <= '{rnct_pkg::MODE_L2, 1'b0, 32'h1_0000, 32'h1_0000, 32'd0, 16'd1, 16'hFFFF};
			main_sum <= 0;
			diff_sum <= 0;
			ovf <= 0;
			fail_count <= 0;
			pending <= 0;
			vectors_seen <= 0;
			verdicts_due.delete();
		end else begin
			// register write
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					rnct_pkg::REG_MODE: cfg.test_mode <= pwdata[1:0];
					rnct_pkg::REG_SCALE_EN: cfg.scale_enable <= pwdata[0];
					rnct_pkg::REG_ALG_COEF: cfg.algebraic_coef <= pwdata;
					rnct_pkg::REG_RES_SCALE: cfg.result_scale <= pwdata;
					rnct_pkg::REG_TOL: cfg.tolerance <= pwdata;
					rnct_pkg::REG_FIRST: cfg.range_first <= pwdata[15:0];
					rnct_pkg::REG_LAST: cfg.range_last <= pwdata[15:0];
					default: ;
				endcase
			end
			// accepted element word
			if (push && !full) begin
				logic [63:0] ms, ds;
				logic o;
				ms = main_sum;
				ds = diff_sum;
				o = ovf;
				if ((cfg.test_mode == rnct_pkg::MODE_L2 || cfg.test_mode == rnct_pkg::MODE_MAX) &&
						element_index >= cfg.range_first && element_index <= cfg.range_last) begin
					s = 0;
					m = residual_value[31] ? -residual_value : residual_value;
					if (cfg.scale_enable) m = qprod(m, element_scale, s);
					if (!is_differential) m = qprod(m, cfg.algebraic_coef, s);
					if (s) o = 1'b1;
					ms = fold(ms, m, o);
					if (is_differential) ds = fold(ds, m, o);
				end
				if (last_element) begin
					dummy = 0;
					v.tv = qprod(closing(ms), cfg.result_scale, dummy);
					v.dv = closing(ds);
					v.div = o;
					v.conv = (v.tv <= cfg.tolerance) && others_converged && !o;
					verdicts_due.insert(verdicts_due.size(), v);
					ms = 0;
					ds = 0;
					o = 0;
				end
				main_sum <= ms;
				diff_sum <= ds;
				ovf <= o;
			end
			// accepted result word
			if (pop && !empty) begin
				if (verdicts_due.size() == 0) begin
					$error("result word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					v = verdicts_due.pop_front();
					got = '{test_value, diff_test_value, converged, diverged};
					if (got !== v) begin
						if (got.tv !== v.tv) $error("test_value exp %h got %h", v.tv, got.tv);
						if (got.dv !== v.dv)
							$error("diff_test_value exp %h got %h", v.dv, got.dv);
						if (got.conv !== v.conv)
							$error("converged exp %b got %b", v.conv, got.conv);
						if (got.div !== v.div)
							$error("diverged exp %b got %b", v.div, got.div);
						fail_count <= fail_count + 1;
					end
				end
				vectors_seen <= vectors_seen + 1;
			end
			pending <= verdicts_due.size();
		end
	end
endmodule

// ----- test/tb.sv -----
// stimulus top for the residual norm convergence test: clock, reset, register
// phases, element vectors; depends on rnct_pkg, the block and rnct_checker
module tb;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0, pop = 0, full, empty, pready;
	logic [31:0] residual_value = 0, element_scale = 0;
	logic is_differential = 0, others_converged = 0, last_element = 0;
	logic [15:0] element_index = 1;
	logic [31:0] test_value, diff_test_value, prdata;
	logic converged, diverged;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [rnct_pkg::ADDR_W-1:0] paddr = 0;
	logic [31:0] pwdata = 0;
	int fail_count, pending, vectors_seen;
	int send_idle = 0, recv_idle = 0, quiet = 0, words = 0;
	logic [31:0] alg_coef;
	logic [15:0] r_first, r_last;

	always #4 clk = ~clk;

	residual_norm_convergence_test u_dut (.*);
	rnct_checker u_chk (.*);

	// receiver: random stalls
	always @(negedge clk) pop <= ($urandom_range(99) >= recv_idle);

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// release the element port, wait for all results plus the vector-end latency
	task automatic drain();
		push <= 0;
		while (pending != 0 || u_chk.verdicts_due.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// push stays high after a word until the next word or drain changes it
	task automatic send(input logic [31:0] r, input logic [31:0] s, input logic d,
			input logic [15:0] i, input logic o, input logic l);
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		residual_value <= r; element_scale <= s; is_differential <= d;
		element_index <= i; others_converged <= o; last_element <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		words++;
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(4))
			0: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
			1: return $urandom_range(32'h3_0000);
			2: return -$urandom_range(32'h3_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_q();
		case ($urandom_range(3))
			0: return $urandom;
			default: return $urandom_range(32'h2_0000);
		endcase
	endfunction

	task automatic random_vectors(input int count);
		int n;
		while (count > 0) begin
			n = $urandom_range(1, 8);
			for (int k = 1; k <= n; k++) begin
				send(rand_val(), rand_q(), $urandom_range(1),
					$urandom_range(5) == 0 ? 16'($urandom) : 16'(k),
					$urandom_range(3) != 0, k == n);
				count--;
			end
		end
	endtask

	task automatic random_config(input int ph);
		reg_write(rnct_pkg::REG_MODE, 32'(ph < 3 ? 2'(ph) : 2'($urandom_range(3))));
		reg_write(rnct_pkg::REG_SCALE_EN, $urandom_range(1));
		alg_coef = ($urandom_range(1)) ? $urandom : $urandom_range(32'h2_0000);
		reg_write(rnct_pkg::REG_ALG_COEF, alg_coef);
		reg_write(rnct_pkg::REG_RES_SCALE, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF :
			$urandom_range(32'h2_0000));
		reg_write(rnct_pkg::REG_TOL, ($urandom_range(1)) ? $urandom : $urandom_range(32'h4_0000));
		r_first = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 6)) : 16'd1;
		r_last = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 8)) : 16'hFFFF;
		reg_write(rnct_pkg::REG_FIRST, 32'(r_first));
		reg_write(rnct_pkg::REG_LAST, 32'(r_last));
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: defaults, extremes, skipped last, empty range
		send(32'h8000_0000, 32'hFFFF_FFFF, 0, 16'd1, 1, 0);
		send(32'h7FFF_FFFF, 32'd0, 1, 16'hFFFF, 1, 1);
		send(32'h0001_0000, 32'd0, 1, 16'd0, 1, 1);
		send(32'hFFFF_0000, 32'd0, 0, 16'd2, 1, 1);
		drain();
		reg_write(rnct_pkg::REG_MODE, 32'(rnct_pkg::MODE_MAX));
		reg_write(rnct_pkg::REG_SCALE_EN, 32'd1);
		reg_write(rnct_pkg::REG_ALG_COEF, 32'hFFFF_FFFF);
		reg_write(rnct_pkg::REG_RES_SCALE, 32'hFFFF_FFFF);
		reg_write(rnct_pkg::REG_TOL, 32'hFFFF_FFFF);
		send(32'h0000_0001, 32'hFFFF_FFFF, 0, 16'd1, 1, 0);
		send(32'hFFFF_FFFF, 32'h0001_0000, 1, 16'd2, 1, 1);
		send(32'h0002_0000, 32'h0000_8000, 1, 16'd3, 1, 1);
		drain();
		reg_write(rnct_pkg::REG_MODE, 32'(rnct_pkg::MODE_NONE));
		reg_write(rnct_pkg::REG_FIRST, 32'd5);
		reg_write(rnct_pkg::REG_LAST, 32'd3);
		send(32'h1234_5678, 32'h0001_0000, 1, 16'd4, 1, 1);
		drain();
		// unused mode code behaves as no test
		reg_write(rnct_pkg::REG_MODE, 32'd3);
		send(32'h1234_5678, 32'h0001_0000, 0, 16'd4, 0, 1);
		drain();
		// random phases under three idling patterns
		for (int ph = 0; ph < 12; ph++) begin
			send_idle = (ph < 4) ? 28 : (ph < 8) ? 84 : 0;
			recv_idle = (ph < 4) ? 84 : (ph < 8) ? 28 : 0;
			random_config(ph % 4);
			random_vectors(165);
			drain();
		end
		$display("covered %0d element words and %0d vector results over all modes",
			words, vectors_seen);
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
